>>> hdl/oant_pkg.sv
// Package for the open addressed name table: shared types, codes and defaults.
// Used by the core and its compare-subtract unit.
`timescale 1ns / 1ps
package oant_pkg;

   localparam int unsigned TABLE_SLOTS_DEF = 1013;
   localparam int unsigned NAME_BYTES_DEF  = 32;
   localparam int unsigned PROBE_STEP      = 7;
   localparam int unsigned HASH_W          = 32;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_EXPORT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_CONFLICT  = 3'd2,
      ST_FULL      = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_META_RD,
      S_META_CHK,
      S_NAME_RD,
      S_NAME_CHK,
      S_STEP,
      S_HIT,
      S_FILL,
      S_REMOVE,
      S_DONE
   } state_type;

endpackage

>>> hdl/oant_req_if.sv
// Request channel of the name table: one name character per transaction.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps
interface oant_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  name_char;
   logic        name_last;
   logic [7:0]  owner_id;
   logic [23:0] entry_address;
   logic [7:0]  arg_count;

   modport source (output valid, op, name_char, name_last, owner_id, entry_address,
                   arg_count, input ready);
   modport sink   (input valid, op, name_char, name_last, owner_id, entry_address,
                   arg_count, output ready);
endinterface

>>> hdl/oant_rsp_if.sv
// Response channel of the name table: one transaction per completed operation.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps
interface oant_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  found_owner;
   logic [23:0] found_address;
   logic [7:0]  found_arg_count;

   modport source (output valid, status, found_owner, found_address, found_arg_count,
                   input ready);
   modport sink   (input valid, status, found_owner, found_address, found_arg_count,
                   output ready);
endinterface

>>> hdl/oant_csub.sv
// Shared compare-subtract unit: reduces a value below twice the slot count
// to below the slot count. Serves the hash reduction and the probe wrap.
`timescale 1ns / 1ps
module oant_csub #(
   parameter int unsigned TABLE_SLOTS = oant_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned SLOT_W      = 10
) (
   input  logic [SLOT_W:0]   operand,
   output logic [SLOT_W-1:0] result
);
   localparam logic [SLOT_W:0] MODULUS = (SLOT_W+1)'(TABLE_SLOTS);

   logic [SLOT_W:0] diff;

   // subtract the modulus once when the operand reaches it
   always_comb begin
      diff = operand - MODULUS;
      if (operand >= MODULUS) begin
         result = diff[SLOT_W-1:0];
      end else begin
         result = operand[SLOT_W-1:0];
      end
   end
endmodule

>>> hdl/open_addressed_name_table_core.sv
// Name table core: hash accumulation, slot probing, name compare and update.
// Depends on oant_pkg, oant_req_if, oant_rsp_if and oant_csub.
//
//  channel | dir | handshake    | payload
//  req_bus | in  | valid/ready  | op, name_char, name_last, owner_id, entry_address, arg_count
//  rsp_bus | out | valid/ready  | status, found_owner, found_address, found_arg_count
//
// A character that is not the last is folded into the hash and the name buffer.
// The last one starts a reduction of the hash (a reciprocal multiply for the
// quotient, then one pass through the compare-subtract unit), then probes slot
// by slot (read, check, step) and compares stored names byte by byte (read,
// check); slot records come from the single read port of the slot record memory.
// Filling a new entry copies the name bytes, then writes the record; remove
// sweeps all TABLE_SLOTS slots. After reset a clearing pass over all slots
// runs before the first transaction is taken. A stalled response holds; the
// next name's characters are accepted while it waits.
`timescale 1ns / 1ps
module open_addressed_name_table_core #(
   parameter int unsigned TABLE_SLOTS = oant_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned NAME_BYTES  = oant_pkg::NAME_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   oant_req_if.sink    req_bus,
   oant_rsp_if.source  rsp_bus
);
   import oant_pkg::*;

   localparam int unsigned SLOT_W     = $clog2(TABLE_SLOTS);
   localparam int unsigned NB_W       = $clog2(NAME_BYTES);
   localparam int unsigned LEN_W      = $clog2(NAME_BYTES + 1);
   localparam int unsigned NAME_DEPTH = TABLE_SLOTS * (2 ** NB_W);
   localparam logic [HASH_W-1:0] HASH_RECIP =
      HASH_W'((64'd1 << HASH_W) / 64'(TABLE_SLOTS));
   localparam logic [SLOT_W:0]   SLOT_MOD   = (SLOT_W+1)'(TABLE_SLOTS);

   typedef struct packed {
      logic             used;
      logic [7:0]       owner;
      logic [LEN_W-1:0] len;
      logic [23:0]      addr;
      logic [7:0]       args;
   } meta_type;

   // memories
   meta_type             meta_mem [TABLE_SLOTS];
   logic [7:0]           name_mem [NAME_DEPTH];
   logic [7:0]           pname_ff [NAME_BYTES];

   meta_type             meta_q_ff;
   logic [7:0]           name_q_ff;

   // control and datapath registers
   state_type            state_ff, state_in;
   logic [HASH_W-1:0]    hash_ff, hash_in;
   logic [LEN_W-1:0]     plen_ff, plen_in;
   logic [1:0]           op_ff, op_in;
   logic [7:0]           owner_ff, owner_in;
   logic [23:0]          addr_ff, addr_in;
   logic [7:0]           args_ff, args_in;
   logic [SLOT_W:0]      quo_ff, quo_in;
   logic [4:0]           bit_cnt_ff, bit_cnt_in;
   logic [SLOT_W-1:0]    home_ff, home_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic [SLOT_W-1:0]    free_ff, free_in;
   logic                 free_vld_ff, free_vld_in;
   logic [NB_W-1:0]      idx_ff, idx_in;
   logic [SLOT_W:0]      sweep_ff, sweep_in;
   logic                 rm_vld_ff, rm_vld_in;
   logic [SLOT_W-1:0]    rm_slot_ff, rm_slot_in;
   status_type           res_status_ff, res_status_in;
   logic [7:0]           res_owner_ff, res_owner_in;
   logic [23:0]          res_addr_ff, res_addr_in;
   logic [7:0]           res_args_ff, res_args_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_owner_ff, rsp_owner_in;
   logic [23:0]          rsp_addr_ff, rsp_addr_in;
   logic [7:0]           rsp_args_ff, rsp_args_in;

   // combinational helpers
   logic                 req_fire;
   logic                 load_ok;
   logic [7:0]           ch_low;
   logic [HASH_W-1:0]    hash_upd;
   logic [2*HASH_W-1:0]  hash_prod;
   logic [2*SLOT_W+1:0]  quo_mul;
   logic [SLOT_W:0]      rem_est;
   logic                 too_long_in;
   logic [SLOT_W:0]      csub_operand;
   logic [SLOT_W-1:0]    csub_result;
   logic                 slot_match;
   logic                 name_eq;
   logic                 name_end;
   logic                 step_wrap;
   logic                 fill_more;
   logic [7:0]           pname_rd;
   logic                 pname_we;
   logic [NB_W-1:0]      pname_wa;
   logic                 meta_we;
   logic [SLOT_W-1:0]    meta_wa;
   meta_type             meta_wd;
   logic [SLOT_W-1:0]    meta_ra;
   logic                 name_we;
   logic [SLOT_W+NB_W-1:0] name_wa;
   logic [SLOT_W+NB_W-1:0] name_ra;

   oant_csub #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_csub (
      .operand (csub_operand),
      .result  (csub_result)
   );

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign load_ok       = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.found_owner     = rsp_owner_ff;
   assign rsp_bus.found_address   = rsp_addr_ff;
   assign rsp_bus.found_arg_count = rsp_args_ff;

   // fold a lowercased character into the running hash
   always_comb begin
      if (req_bus.name_char inside {[8'h41:8'h5A]}) begin
         ch_low = req_bus.name_char + 8'h20;
      end else begin
         ch_low = req_bus.name_char;
      end
      hash_upd = hash_ff + {24'd0, ch_low} + {hash_ff[HASH_W-4:0], 3'b000}
                 + {29'd0, hash_ff[HASH_W-1:HASH_W-3]};
   end

   // length after this character, and the too-long flag it implies
   always_comb begin
      plen_in = plen_ff;
      if (req_fire && req_bus.name_char != 8'd0) begin
         if (plen_ff < LEN_W'(NAME_BYTES - 1)) begin
            plen_in = plen_ff + LEN_W'(1);
         end else begin
            plen_in = LEN_W'(NAME_BYTES);
         end
      end
      if (state_ff == S_DONE && load_ok) begin
         plen_in = '0;
      end
   end
   assign too_long_in = (plen_in == LEN_W'(NAME_BYTES));

   // reciprocal estimate of the quotient; the remainder it leaves is below twice the modulus
   assign hash_prod = hash_ff * HASH_RECIP;
   assign quo_mul   = quo_ff * SLOT_MOD;
   assign rem_est   = hash_ff[SLOT_W:0] - quo_mul[SLOT_W:0];

   // shared unit operand: estimated remainder of the hash, or the next probe
   always_comb begin
      if (state_ff == S_MOD) begin
         csub_operand = rem_est;
      end else begin
         csub_operand = {1'b0, cur_ff} + (SLOT_W+1)'(PROBE_STEP);
      end
   end

   // slot and byte compare terms
   assign pname_rd   = pname_ff[idx_ff];
   assign slot_match = meta_q_ff.used && (meta_q_ff.owner != 8'd0)
                       && (meta_q_ff.len == plen_ff);
   assign name_eq    = (name_q_ff == pname_rd);
   assign name_end   = ((LEN_W'(idx_ff) + LEN_W'(1)) == plen_ff);
   assign step_wrap  = (csub_result == home_ff);
   assign fill_more  = (LEN_W'(idx_ff) != plen_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sweep_ff == (SLOT_W+1)'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire && req_bus.name_last) begin
               if (req_bus.op == OP_REMOVE) begin
                  state_in = S_REMOVE;
               end else if (req_bus.op != OP_LOOKUP && req_bus.op != OP_EXPORT) begin
                  state_in = S_DONE;
               end else if (too_long_in) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (bit_cnt_ff == 5'd0) begin
               state_in = S_META_RD;
            end
         end
         S_META_RD:  state_in = S_META_CHK;
         S_META_CHK: begin
            if (!slot_match) begin
               state_in = S_STEP;
            end else if (plen_ff == '0) begin
               state_in = S_HIT;
            end else begin
               state_in = S_NAME_RD;
            end
         end
         S_NAME_RD:  state_in = S_NAME_CHK;
         S_NAME_CHK: begin
            if (!name_eq) begin
               state_in = S_STEP;
            end else if (name_end) begin
               state_in = S_HIT;
            end else begin
               state_in = S_NAME_RD;
            end
         end
         S_STEP: begin
            if (!step_wrap) begin
               state_in = S_META_RD;
            end else if (op_ff == OP_EXPORT && free_vld_ff) begin
               state_in = S_FILL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_HIT:  state_in = S_DONE;
         S_FILL: begin
            if (!fill_more) begin
               state_in = S_DONE;
            end
         end
         S_REMOVE: begin
            if (sweep_ff == (SLOT_W+1)'(TABLE_SLOTS)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      hash_in       = hash_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      addr_in       = addr_ff;
      args_in       = args_ff;
      quo_in        = quo_ff;
      bit_cnt_in    = bit_cnt_ff;
      home_in       = home_ff;
      cur_in        = cur_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      idx_in        = idx_ff;
      sweep_in      = sweep_ff;
      rm_vld_in     = 1'b0;
      rm_slot_in    = rm_slot_ff;
      res_status_in = res_status_ff;
      res_owner_in  = res_owner_ff;
      res_addr_in   = res_addr_ff;
      res_args_in   = res_args_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_args_in   = rsp_args_ff;
      pname_we      = 1'b0;
      pname_wa      = plen_ff[NB_W-1:0];
      meta_we       = 1'b0;
      meta_wa       = cur_ff;
      meta_wd       = meta_q_ff;
      name_we       = 1'b0;
      name_wa       = {free_ff, idx_ff};
      name_ra       = {cur_ff, idx_ff};
      meta_ra       = cur_ff;

      case (state_ff)
         S_CLEAR: begin
            meta_we  = 1'b1;
            meta_wa  = sweep_ff[SLOT_W-1:0];
            meta_wd  = '0;
            sweep_in = sweep_ff + (SLOT_W+1)'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               // store the character and advance the hash
               if (req_bus.name_char != 8'd0) begin
                  hash_in = hash_upd;
                  if (plen_ff < LEN_W'(NAME_BYTES - 1)) begin
                     pname_we = 1'b1;
                  end
               end
               if (req_bus.name_last) begin
                  op_in         = req_bus.op;
                  owner_in      = req_bus.owner_id;
                  addr_in       = req_bus.entry_address;
                  args_in       = req_bus.arg_count;
                  bit_cnt_in    = 5'd1;
                  free_vld_in   = 1'b0;
                  sweep_in      = '0;
                  res_owner_in  = 8'd0;
                  res_addr_in   = 24'd0;
                  res_args_in   = 8'd0;
                  if (req_bus.op == OP_REMOVE) begin
                     res_status_in = ST_OK;
                  end else if (req_bus.op != OP_LOOKUP && req_bus.op != OP_EXPORT) begin
                     res_status_in = ST_NOT_FOUND;
                  end else if (too_long_in) begin
                     res_status_in = ST_TOO_LONG;
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
               end
            end
         end
         S_MOD: begin
            // latch the quotient estimate, then correct the remainder in the shared unit
            bit_cnt_in = bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == 5'd0) begin
               home_in = csub_result;
               cur_in  = csub_result;
            end else begin
               quo_in  = hash_prod[HASH_W+SLOT_W:HASH_W];
            end
         end
         S_META_CHK: begin
            // remember the first free slot in probe order
            if (!meta_q_ff.used && !free_vld_ff) begin
               free_in     = cur_ff;
               free_vld_in = 1'b1;
            end
            idx_in = '0;
         end
         S_NAME_CHK: begin
            idx_in = idx_ff + NB_W'(1);
         end
         S_STEP: begin
            cur_in = csub_result;
            idx_in = '0;
            if (step_wrap) begin
               if (op_ff == OP_EXPORT && !free_vld_ff) begin
                  res_status_in = ST_FULL;
               end else begin
                  res_status_in = ST_NOT_FOUND;
               end
            end
         end
         S_HIT: begin
            if (op_ff == OP_EXPORT && meta_q_ff.owner == owner_ff) begin
               // update the found entry in place
               meta_we       = 1'b1;
               meta_wa       = cur_ff;
               meta_wd.addr  = addr_ff;
               meta_wd.args  = args_ff;
               res_status_in = ST_OK;
               res_owner_in  = owner_ff;
               res_addr_in   = addr_ff;
               res_args_in   = args_ff;
            end else begin
               res_status_in = (op_ff == OP_EXPORT) ? ST_CONFLICT : ST_OK;
               res_owner_in  = meta_q_ff.owner;
               res_addr_in   = meta_q_ff.addr;
               res_args_in   = meta_q_ff.args;
            end
         end
         S_FILL: begin
            if (fill_more) begin
               // copy one name byte into the free slot
               name_we = 1'b1;
               idx_in  = idx_ff + NB_W'(1);
            end else begin
               meta_we       = 1'b1;
               meta_wa       = free_ff;
               meta_wd.used  = 1'b1;
               meta_wd.owner = owner_ff;
               meta_wd.len   = plen_ff;
               meta_wd.addr  = addr_ff;
               meta_wd.args  = args_ff;
               res_status_in = ST_OK;
               res_owner_in  = owner_ff;
               res_addr_in   = addr_ff;
               res_args_in   = args_ff;
            end
         end
         S_REMOVE: begin
            // read one slot a cycle, clear it in the cycle after if the owner matches
            meta_ra = sweep_ff[SLOT_W-1:0];
            if (sweep_ff != (SLOT_W+1)'(TABLE_SLOTS)) begin
               rm_vld_in  = 1'b1;
               rm_slot_in = sweep_ff[SLOT_W-1:0];
               sweep_in   = sweep_ff + (SLOT_W+1)'(1);
            end
            if (rm_vld_ff && meta_q_ff.owner == owner_ff) begin
               meta_we       = 1'b1;
               meta_wa       = rm_slot_ff;
               meta_wd.used  = 1'b0;
               meta_wd.owner = 8'd0;
            end
         end
         S_DONE: begin
            // hand the result to the output register and drop the name
            if (load_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_owner_in  = res_owner_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_args_in   = res_args_ff;
               hash_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         hash_ff      <= '0;
         plen_ff      <= '0;
         sweep_ff     <= '0;
         rm_vld_ff    <= 1'b0;
         free_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         plen_ff      <= plen_in;
         sweep_ff     <= sweep_in;
         rm_vld_ff    <= rm_vld_in;
         free_vld_ff  <= free_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      addr_ff       <= addr_in;
      args_ff       <= args_in;
      quo_ff        <= quo_in;
      bit_cnt_ff    <= bit_cnt_in;
      home_ff       <= home_in;
      cur_ff        <= cur_in;
      free_ff       <= free_in;
      idx_ff        <= idx_in;
      rm_slot_ff    <= rm_slot_in;
      res_status_ff <= res_status_in;
      res_owner_ff  <= res_owner_in;
      res_addr_ff   <= res_addr_in;
      res_args_ff   <= res_args_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_args_ff   <= rsp_args_in;
   end

   // pending name buffer
   always_ff @(posedge clock) begin
      if (pname_we) begin
         pname_ff[pname_wa] <= ch_low;
      end
   end

   // slot record memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_q_ff <= meta_mem[meta_ra];
   end

   // stored name memory
   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[name_wa] <= pname_rd;
      end
      name_q_ff <= name_mem[name_ra];
   end

endmodule

>>> hdl/oant_checker.sv
// Port-level checks for the name table core, attached by bind.
// Depends on open_addressed_name_table_core and its interface ports.
`timescale 1ns / 1ps
module oant_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [23:0] rsp_found_address
);
   // the clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // the request side closes after the final character while the operation runs
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken while operation runs");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd4)
      else $error("undefined status code");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_found_address))
      else $error("stalled response changed");
endmodule

bind open_addressed_name_table_core oant_checker u_oant_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_last          (req_bus.name_last),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_found_address (rsp_bus.found_address)
);
